>>> rtl/rounded_rect_vertex_generator_core_macros.svh
// Assertion macros for the rounded rectangle vertex generator.
// Expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef ROUNDED_RECT_VERTEX_GENERATOR_CORE_MACROS_SVH
`define ROUNDED_RECT_VERTEX_GENERATOR_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RRVG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrvg assertion failed");

// Check that cons holds in the cycle after ante.
`define RRVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrvg assertion failed");

`endif

>>> rtl/rrvg_pkg.sv
// Shared constants and types of the rounded rectangle vertex generator.
// No dependencies.
`default_nettype none

package rrvg_pkg;

  localparam int unsigned TRIG_FRACTION_BITS_DEF = 16;
  localparam int unsigned MAX_VERTICES           = 1024;

  // Q30 constants
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Sine series: divisors 72, 42, 20, 6 as a shift and an odd factor
  localparam int unsigned TAYLOR_SHIFT [4] = '{3, 1, 2, 1};
  localparam int unsigned TAYLOR_ODD   [4] = '{9, 21, 5, 3};

  // Register stages of the sine unit
  localparam int unsigned SIN_LAT = 14;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_RES    = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> rtl/rrvg_in_if.sv
// Vertex index request channel.
// No dependencies.
`default_nettype none

interface rrvg_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] vertex_index;

  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface

`default_nettype wire

>>> rtl/rrvg_out_if.sv
// Vertex result channel: position, texture coordinate and range flag.
// No dependencies.
`default_nettype none

interface rrvg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [15:0] tex_u;
  logic        [15:0] tex_v;
  logic               index_invalid;

  modport source (output valid, output pos_x, output pos_y, output tex_u,
                  output tex_v, output index_invalid, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input tex_u,
                  input tex_v, input index_invalid, output ready);
endinterface

`default_nettype wire

>>> rtl/rrvg_sin.sv
// Pipelined Q30 sine by a nested series to the ninth power, 14 stages.
// Depends on rrvg_pkg.
`default_nettype none

module rrvg_sin (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [30:0] t_i,
  output logic      [30:0] sin_o
);
  import rrvg_pkg::*;

  logic [30:0] t_w  [5];
  logic [31:0] t2_w [5];
  logic [30:0] a_w  [5];

  logic [30:0] t_a_q;
  logic [31:0] t2_a_q;
  logic [61:0] sq;
  logic [61:0] prod_f;
  logic [30:0] sin_q;

  // Square the angle
  assign sq = 62'(t_i) * 62'(t_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_a_q  <= t_i;
      t2_a_q <= sq[61:30];
    end
  end

  assign t_w[0]  = t_a_q;
  assign t2_w[0] = t2_a_q;
  assign a_w[0]  = ONE_Q30;

  // One series term: multiply, reciprocal multiply, correct and subtract
  for (genvar k = 0; k < 4; k++) begin : g_term
    localparam int unsigned D  = TAYLOR_ODD[k];
    localparam int unsigned SH = TAYLOR_SHIFT[k];
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);

    logic [62:0] prod_m;
    logic [63:0] prod_r;
    logic [33:0] rr;
    logic [31:0] qq;
    logic [31:0] m_q, xs_q, q0_q, t2m_q, t2r_q, t2c_q;
    logic [30:0] tm_q, tr_q, tc_q, a_q;

    assign prod_m = 63'(t2_w[k]) * 63'(a_w[k]);
    assign prod_r = 64'(m_q >> SH) * 64'(RECIP);
    assign rr     = 34'(xs_q) - 34'(q0_q) * 34'(D);
    assign qq     = q0_q + 32'(rr >= 34'(D));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q   <= prod_m[61:30];
        tm_q  <= t_w[k];
        t2m_q <= t2_w[k];
        xs_q  <= m_q >> SH;
        q0_q  <= prod_r[63:32];
        tr_q  <= tm_q;
        t2r_q <= t2m_q;
        a_q   <= ONE_Q30 - qq[30:0];
        tc_q  <= tr_q;
        t2c_q <= t2r_q;
      end
    end

    assign t_w[k+1]  = tc_q;
    assign t2_w[k+1] = t2c_q;
    assign a_w[k+1]  = a_q;
  end

  // Final multiply by the angle
  assign prod_f = 62'(t_w[4]) * 62'(a_w[4]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= prod_f[60:30];
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire

>>> rtl/rrvg_fdiv.sv
// Bit-serial divider for the side factors: (num << 30) / den.
// Depends on no package.
`default_nettype none

module rrvg_fdiv (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [16:0] num_i,
  input  wire logic [16:0] den_i,
  output logic             done_o,
  output logic      [30:0] quot_o
);
  localparam int unsigned NUM_W = 47;
  localparam logic [5:0]  LAST  = 6'(NUM_W - 1);

  logic             active_q;
  logic [5:0]       cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] nsh_q;
  logic [17:0]      rem_q;
  logic [30:0]      quot_q;
  logic [17:0]      r2;
  logic             ge;

  // One restoring step
  assign r2 = {rem_q[16:0], nsh_q[NUM_W-1]};
  assign ge = r2 >= {1'b0, den_i};

  // Sequence the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= active_q && (cnt_q == LAST) && !start_i;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == LAST) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // Shift numerator and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nsh_q  <= {num_i, 30'b0};
      rem_q  <= '0;
      quot_q <= '0;
    end else if (active_q) begin
      nsh_q  <= nsh_q << 1;
      rem_q  <= ge ? r2 - {1'b0, den_i} : r2;
      quot_q <= {quot_q[29:0], ge};
    end
  end

  assign done_o = done_q;
  // A zero side gives a zero factor
  assign quot_o = (den_i == '0) ? '0 : quot_q;

endmodule

`default_nettype wire

>>> rtl/rounded_rect_vertex_generator_core.sv
// Rounded rectangle outline vertex generator, top level.
// Depends on rrvg_pkg, rrvg_in_if, rrvg_out_if, rrvg_sin, rrvg_fdiv and the macro header.
//
// Usage:
//   in_if carries a vertex index, out_if returns one vertex per request:
//   signed Q8.8 position, Q1.15 texture coordinate and a range flag.
//   Both channels move a request at a clock edge where valid and ready are high.
//   One request enters per cycle unless the receiver stalls or a factor update runs.
//   The pipeline runs through the phase divider (8 stages, 4 quotient bits each),
//   the 14-stage sine unit and the stages that scale, round and saturate.
//   A receiver stall freezes the whole pipeline; no request is lost or repeated.
//   Configuration writes go through cfg_we_i, cfg_idx_i and cfg_wdata_i.
//   After each write the side factors are recomputed by a bit-serial divider:
//   in_if.ready stays low after the last write until its divider run is done.
//   Reset loads radius 0, size 1.0 by 1.0 and 32 vertices; the factors for
//   these values are loaded at once, so requests are taken right after reset.
`default_nettype none

module rounded_rect_vertex_generator_core #(
  parameter int unsigned TRIG_FRACTION_BITS = rrvg_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rrvg_in_if.sink                in_if,
  rrvg_out_if.source             out_if,
  input  wire logic              cfg_we_i,
  input  wire rrvg_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i
);
  import rrvg_pkg::*;

  `include "rounded_rect_vertex_generator_core_macros.svh"

  localparam int unsigned F   = TRIG_FRACTION_BITS;
  localparam int unsigned TW  = F + 2;
  localparam int unsigned PW  = F + 21;
  localparam int unsigned BW  = F + 36;
  localparam int unsigned NDV = 8;
  localparam int unsigned NST = 1 + NDV + 2 + SIN_LAT + 3;
  localparam logic [10:0] RES_CAP = 11'(MAX_VERTICES);
  localparam logic signed [BW-1:0] ONE_B = BW'(1) <<< (31 + F);

  typedef struct packed {
    logic       inv;
    logic       right;
    logic       top;
    logic [1:0] quad;
  } side_t;

  typedef struct packed {
    logic [10:0] rem;
    logic [31:0] q;
  } div_t;

  // Four steps of the phase division
  function automatic div_t div4(input div_t x, input logic [10:0] d);
    div_t       y;
    logic [11:0] r2;
    y = x;
    for (int s = 0; s < 4; s++) begin
      r2 = {y.rem, 1'b0};
      if (r2 >= {1'b0, d}) begin
        y.rem = 11'(r2 - {1'b0, d});
        y.q   = {y.q[30:0], 1'b1};
      end else begin
        y.rem = r2[10:0];
        y.q   = {y.q[30:0], 1'b0};
      end
    end
    return y;
  endfunction

  // Round Q30 to F fraction bits and cap at one
  function automatic logic [F:0] to_trig(input logic [30:0] q);
    logic [31:0] sum;
    logic [31:0] v;
    sum = 32'(q) + (32'd1 << (29 - F));
    v   = sum >> (30 - F);
    if (v > (32'd1 << F)) begin
      return (F + 1)'(32'd1 << F);
    end
    return v[F:0];
  endfunction

  function automatic logic signed [15:0] sat_pos(input logic signed [19:0] q);
    if (q > 20'sd32767) begin
      return 16'sh7fff;
    end else if (q < -20'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  function automatic logic [15:0] to_tex(input logic signed [BW-1:0] raw);
    logic signed [BW-1:0] sum;
    logic signed [18:0]   q;
    sum = raw + (BW'(1) <<< (16 + F));
    q   = 19'(sum >>> (17 + F));
    if (raw < 0) begin
      return 16'h0000;
    end else if (q > 19'sd32768) begin
      return 16'h8000;
    end
    return q[15:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration and side factors
  logic [15:0] radius_q, width_q, height_q;
  logic [10:0] res_q;
  logic        cfg_wr_q, busy_q;
  logic [30:0] fx_q, fy_q;
  logic [16:0] r1;
  logic [16:0] r2x;
  logic [10:0] res_eff;
  logic        done_x, done_y;
  logic [30:0] quot_x, quot_y;

  assign r2x     = {radius_q, 1'b0};
  assign res_eff = (res_q > RES_CAP) ? RES_CAP : res_q;

  // Clamp radius to half the smaller side
  always_comb begin
    r1 = r2x;
    if ({1'b0, width_q} < r1) begin
      r1 = {1'b0, width_q};
    end
    if ({1'b0, height_q} < r1) begin
      r1 = {1'b0, height_q};
    end
  end

  // Hold registers, start factor update after a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd0;
      width_q  <= 16'd256;
      height_q <= 16'd256;
      res_q    <= 11'd32;
      cfg_wr_q <= 1'b0;
      busy_q   <= 1'b0;
      fx_q     <= ONE_Q30;
      fy_q     <= ONE_Q30;
    end else begin
      cfg_wr_q <= cfg_we_i;
      busy_q   <= cfg_we_i || (busy_q && !(done_x && !cfg_wr_q));
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RADIUS: radius_q <= cfg_wdata_i;
          CFG_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_HEIGHT: height_q <= cfg_wdata_i;
          CFG_RES:    res_q    <= cfg_wdata_i[10:0];
        endcase
      end
      if (done_x) begin
        fx_q <= quot_x;
      end
      if (done_y) begin
        fy_q <= quot_y;
      end
    end
  end

  rrvg_fdiv u_fdiv_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr_q),
    .num_i   (17'(width_q) - r1),
    .den_i   (17'(width_q) + r1),
    .done_o  (done_x),
    .quot_o  (quot_x)
  );

  rrvg_fdiv u_fdiv_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr_q),
    .num_i   (17'(height_q) - r1),
    .den_i   (17'(height_q) + r1),
    .done_o  (done_y),
    .quot_o  (quot_y)
  );

  // ---------------------------------------------------------------------
  // Handshake: the whole pipe advances unless the last stage is stalled
  logic           en, in_acc;
  logic [NST-1:0] v_q;

  assign en           = !v_q[NST-1] || out_if.ready;
  assign in_if.ready  = en && !busy_q;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_if.valid = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_acc};
    end
  end

  // ---------------------------------------------------------------------
  // Input stage, phase division, angle
  side_t       sd_q [NDV+3];
  div_t        dv_q [NDV+1];
  side_t       sd_in;
  logic [12:0] i4;
  logic [12:0] res13;
  logic [60:0] tmul;
  logic [30:0] t9_q, ts_q, tc_q;

  assign i4    = {1'b0, in_if.vertex_index, 2'b00};
  assign res13 = 13'(res_eff);

  always_comb begin
    sd_in.inv   = {1'b0, in_if.vertex_index} >= res_eff;
    sd_in.right = (i4 <= res13) || (i4 > res13 * 13'd3);
    sd_in.top   = {1'b0, in_if.vertex_index, 1'b0} < res13[11:0];
    sd_in.quad  = 2'b00;
  end

  assign tmul = 61'(dv_q[NDV].q[29:0]) * 61'(HALF_PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]     <= sd_in;
      dv_q[0].rem <= {1'b0, in_if.vertex_index};
      dv_q[0].q   <= '0;
      for (int g = 1; g <= NDV; g++) begin
        dv_q[g] <= div4(dv_q[g-1], res_eff);
        sd_q[g] <= sd_q[g-1];
      end
      t9_q            <= tmul[60:30];
      sd_q[NDV+1]     <= {sd_q[NDV].inv, sd_q[NDV].right, sd_q[NDV].top,
                          dv_q[NDV].q[31:30]};
      ts_q            <= t9_q;
      tc_q            <= HALF_PI_Q30 - t9_q;
      sd_q[NDV+2]     <= sd_q[NDV+1];
    end
  end

  // ---------------------------------------------------------------------
  // Sine and cosine, side data delayed alongside
  logic [30:0] sin_q30, cos_q30;
  side_t       sl_q [SIN_LAT];

  rrvg_sin u_sin (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (ts_q),
    .sin_o (sin_q30)
  );

  rrvg_sin u_cos (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (tc_q),
    .sin_o (cos_q30)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sl_q[0] <= sd_q[NDV+2];
      for (int k = 1; k < SIN_LAT; k++) begin
        sl_q[k] <= sl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Round, rotate by quadrant, scale, blend, round and saturate
  logic signed [TW-1:0]   c0s, s0s, c_d, s_d, c_q, s_q;
  side_t                  st_q, sp_q;
  logic signed [17:0]     r1s;
  logic signed [F+19:0]   pcx_d, psy_d, pcx_q, psy_q;
  logic signed [F+33:0]   blx_d, bly_d, blx_q, bly_q;
  logic signed [PW-1:0]   shx, shy, sumx, sumy;
  logic signed [BW-1:0]   fsx, fsy, rawu, rawv;
  logic signed [15:0]     pos_x_q, pos_y_q;
  logic        [15:0]     tex_u_q, tex_v_q;
  logic                   inv_q;

  assign c0s = $signed({1'b0, to_trig(cos_q30)});
  assign s0s = $signed({1'b0, to_trig(sin_q30)});

  always_comb begin
    case (sl_q[SIN_LAT-1].quad)
      2'd0:    begin c_d = c0s;  s_d = s0s;  end
      2'd1:    begin c_d = -s0s; s_d = c0s;  end
      2'd2:    begin c_d = -c0s; s_d = -s0s; end
      default: begin c_d = s0s;  s_d = -c0s; end
    endcase
  end

  assign r1s   = $signed({1'b0, r1});
  assign pcx_d = c_q * r1s;
  assign psy_d = s_q * r1s;
  assign blx_d = $signed({1'b0, ONE_Q30 - fx_q}) * c_q;
  assign bly_d = $signed({1'b0, ONE_Q30 - fy_q}) * s_q;

  assign shx  = $signed(PW'(17'(width_q) - r1)) <<< F;
  assign shy  = $signed(PW'(17'(height_q) - r1)) <<< F;
  assign sumx = PW'(pcx_q) + (sp_q.right ? shx : -shx) + (PW'(1) <<< F);
  assign sumy = PW'(psy_q) + (sp_q.top ? shy : -shy) + (PW'(1) <<< F);

  assign fsx  = $signed(BW'(fx_q)) <<< (F + 1);
  assign fsy  = $signed(BW'(fy_q)) <<< (F + 1);
  assign rawu = ONE_B + (sp_q.right ? fsx : -fsx) + BW'(blx_q);
  assign rawv = ONE_B - ((sp_q.top ? fsy : -fsy) + BW'(bly_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= c_d;
      s_q   <= s_d;
      st_q  <= sl_q[SIN_LAT-1];
      pcx_q <= pcx_d;
      psy_q <= psy_d;
      blx_q <= blx_d;
      bly_q <= bly_d;
      sp_q  <= st_q;
      inv_q <= sp_q.inv;
      if (sp_q.inv) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
        tex_u_q <= '0;
        tex_v_q <= '0;
      end else begin
        pos_x_q <= sat_pos(20'(sumx >>> (F + 1)));
        pos_y_q <= sat_pos(20'(sumy >>> (F + 1)));
        tex_u_q <= to_tex(rawu);
        tex_v_q <= to_tex(rawv);
      end
    end
  end

  assign out_if.pos_x         = pos_x_q;
  assign out_if.pos_y         = pos_y_q;
  assign out_if.tex_u         = tex_u_q;
  assign out_if.tex_v         = tex_v_q;
  assign out_if.index_invalid = inv_q;

  // ---------------------------------------------------------------------
  // Checks
  logic out_zero;

  assign out_zero = (pos_x_q == 16'sd0) && (pos_y_q == 16'sd0) &&
                    (tex_u_q == 16'd0) && (tex_v_q == 16'd0);

  `RRVG_ASSERT_IMP(a_busy_blocks, busy_q, !in_if.ready)
  `RRVG_ASSERT_NEXT(a_cfg_sets_busy, cfg_we_i, busy_q)
  `RRVG_ASSERT_NEXT(a_accept_enters, in_if.valid && in_if.ready, v_q[0])
  `RRVG_ASSERT_IMP(a_invalid_zero, out_if.valid && out_if.index_invalid, out_zero)

endmodule

`default_nettype wire
